[rtl/core/escaped_frame_receiver_assert.svh]
// ---------------------------------------------------------------------------
// escaped_frame_receiver assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is low
// ---------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define EFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escaped_frame_receiver: same-cycle check failed");

// next-cycle implication
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escaped_frame_receiver: next-cycle check failed");

`endif

[rtl/core/efr_pkg.sv]
// ---------------------------------------------------------------------------
// efr_pkg
// types, codes and defaults shared by the escaped frame receiver modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

  // default frame length limit
  localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 2;

  // register reset values
  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'hC0;
  localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'hD0;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'hDB;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_START_CODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_END_CODE    = 2'd1;
  localparam logic [IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  // receiver mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_DATA = 3'b010,
    MODE_ESC  = 3'b100
  } mode_t;

  // control byte set
  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] escape_code;
  } cfg_t;

  // one result item plus its valid flag
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              ovf;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/escaped_frame_receiver.sv]
// ---------------------------------------------------------------------------
// escaped_frame_receiver
// deframes start/end/escape delimited byte streams into payload bytes,
// frame-complete and frame-aborted results
// ---------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_stall, in_rx_byte          | in
//  result   | out_valid, out_stall, out_kind,         | out
//           | out_payload_byte, out_position,         |
//           | out_overflowed                          |
//  config   | cfg_we, cfg_index, cfg_wdata            | in
//
//  one byte per cycle while in_stall is low; a result is registered in the
//  output register, or waits in the skid entry first, before out_valid shows it
//  a skid entry behind the output register takes one more result while the
//  consumer stalls; in_stall rises only when that entry is full
//  synchronous reset returns the receiver to idle and the codes to defaults
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = efr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [efr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [efr_pkg::KIND_W-1:0] out_kind,
  output logic [efr_pkg::BYTE_W-1:0] out_payload_byte,
  output logic [efr_pkg::POS_W-1:0]  out_position,
  output logic                       out_overflowed,
  input  logic                       cfg_we,
  input  logic [efr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [efr_pkg::BYTE_W-1:0] cfg_wdata
);

  efr_pkg::cfg_t    cfg_r;
  efr_pkg::result_t core_res;
  efr_pkg::result_t out_res;
  logic             accept;
  logic             full;

  // control code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= efr_pkg::START_CODE_RST;
      cfg_r.end_code    <= efr_pkg::END_CODE_RST;
      cfg_r.escape_code <= efr_pkg::ESCAPE_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efr_pkg::REG_START_CODE:  cfg_r.start_code  <= cfg_wdata;
        efr_pkg::REG_END_CODE:    cfg_r.end_code    <= cfg_wdata;
        efr_pkg::REG_ESCAPE_CODE: cfg_r.escape_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_stall = full;
  assign accept   = in_valid && !full;

  efr_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .res     (core_res)
  );

  efr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && core_res.valid),
    .push_res  (core_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result fields
  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.data;
  assign out_position     = out_res.pos;
  assign out_overflowed   = out_res.ovf;

endmodule

`default_nettype wire

[rtl/core/efr_core.sv]
// ---------------------------------------------------------------------------
// efr_core
// deframing state machine: unstuffs one byte per transfer and produces
// at most one result for it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "escaped_frame_receiver_assert.svh"

module efr_core #(
  parameter int unsigned MAX_FRAME_BYTES = efr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [efr_pkg::BYTE_W-1:0] rx_byte,
  input  efr_pkg::cfg_t             cfg,
  output efr_pkg::result_t          res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

  efr_pkg::mode_t   mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic                           is_start, is_end, is_esc;
  logic [CNT_W+efr_pkg::POS_W-1:0] cnt_ext;
  logic [efr_pkg::POS_W-1:0]       cnt_pos;

  // code matches and position masked to the port width
  assign is_start = (rx_byte == cfg.start_code);
  assign is_end   = (rx_byte == cfg.end_code);
  assign is_esc   = (rx_byte == cfg.escape_code);
  assign cnt_ext  = {{efr_pkg::POS_W{1'b0}}, cnt_r};
  assign cnt_pos  = cnt_ext[efr_pkg::POS_W-1:0];

  // next state and result for the byte on the input
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    res      = '0;
    res.kind = efr_pkg::KIND_BYTE;
    unique case (mode_r)
      efr_pkg::MODE_DATA: begin
        priority if (is_start) begin
          res.valid = 1'b1;
          res.kind  = efr_pkg::KIND_ABORT;
          res.pos   = cnt_pos;
          res.ovf   = ovf_r;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
        end else if (is_end) begin
          res.valid = 1'b1;
          res.kind  = efr_pkg::KIND_DONE;
          res.pos   = cnt_pos;
          res.ovf   = ovf_r;
          mode_nxt  = efr_pkg::MODE_IDLE;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
        end else if (is_esc) begin
          mode_nxt = efr_pkg::MODE_ESC;
        end else if (cnt_r >= CNT_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          res.valid = 1'b1;
          res.data  = rx_byte;
          res.pos   = cnt_pos;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      efr_pkg::MODE_ESC: begin
        mode_nxt = efr_pkg::MODE_DATA;
        priority if (!(is_start || is_end || is_esc)) begin
          // bad escape drops the frame
          res.valid = 1'b1;
          res.kind  = efr_pkg::KIND_ABORT;
          res.pos   = cnt_pos;
          res.ovf   = ovf_r;
          mode_nxt  = efr_pkg::MODE_IDLE;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
        end else if (cnt_r >= CNT_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          res.valid = 1'b1;
          res.data  = rx_byte;
          res.pos   = cnt_pos;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      default: begin
        // idle: only a start code matters
        mode_nxt = efr_pkg::MODE_IDLE;
        if (is_start) begin
          mode_nxt = efr_pkg::MODE_DATA;
          cnt_nxt  = '0;
          ovf_nxt  = 1'b0;
        end
      end
    endcase
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= efr_pkg::MODE_IDLE;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // checks
  `EFR_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_MAX)
  `EFR_ASSERT_IMPLY(a_ovf_at_limit, clk, rst_n, ovf_r, cnt_r == CNT_MAX)
  `EFR_ASSERT_IMPLY(a_idle_clean, clk, rst_n, mode_r == efr_pkg::MODE_IDLE,
                    (cnt_r == '0) && !ovf_r)
  `EFR_ASSERT_NEXT(a_restart, clk, rst_n,
                   accept && (mode_r == efr_pkg::MODE_DATA) && is_start,
                   (mode_r == efr_pkg::MODE_DATA) && (cnt_r == '0) && !ovf_r)

endmodule

`default_nettype wire

[rtl/core/efr_skid.sv]
// ---------------------------------------------------------------------------
// efr_skid
// output register with one skid entry, so a result can wait on a stalled
// consumer while the next byte is still taken
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  efr_pkg::result_t push_res,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output efr_pkg::result_t out_res
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  efr_pkg::result_t main_r, main_nxt;
  efr_pkg::result_t skid_r, skid_nxt;
  logic             pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  // buffer steering
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    priority if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

[tb/tb_escaped_frame_receiver.sv]
// ---------------------------------------------------------------------------
// tb_escaped_frame_receiver
// self-checking bench for the escaped frame receiver: bytes go in through the
// valid/stall input channel and every result transfer is checked field by
// field against a deframer model kept in the bench. Covers default and
// extreme control codes, coinciding codes, a frame running past the length
// limit, a long consumer hold-off and randomised framed traffic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_escaped_frame_receiver;
  import efr_pkg::*;

  localparam int unsigned FRAME_LIMIT   = MAX_FRAME_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_BYTES   = 40;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              ovf;
  } frame_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_stall;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_payload_byte;
  logic [POS_W-1:0]  out_position;
  logic              out_overflowed;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [BYTE_W-1:0] cfg_wdata;

  // deframer model state and its copy of the control codes
  mode_t             rx_mode     = MODE_IDLE;
  int unsigned       frame_count = 0;
  bit                frame_ovf   = 1'b0;
  logic [BYTE_W-1:0] cur_start   = START_CODE_RST;
  logic [BYTE_W-1:0] cur_end     = END_CODE_RST;
  logic [BYTE_W-1:0] cur_escape  = ESCAPE_CODE_RST;

  frame_result_t pending_results[$];
  frame_result_t head;

  bit          gaps_on       = 1'b1;
  bit          stalls_on     = 1'b1;
  int unsigned hold_request  = 0;
  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frame_items   = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_done   = 0;
  int unsigned frames_killed = 0;
  int unsigned stall_edges   = 0;

  escaped_frame_receiver #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_payload_byte(out_payload_byte),
    .out_position    (out_position),
    .out_overflowed  (out_overflowed),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // deframer model
  // ---------------------------------------------------------------------------
  function automatic frame_result_t make_result(kind_t k, logic [BYTE_W-1:0] d,
                                                int unsigned p, bit o);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    r.pos  = p[POS_W-1:0];
    r.ovf  = o;
    return r;
  endfunction

  // payload byte: kept with its index, or dropped once the frame is full
  function automatic bit keep_payload(input logic [BYTE_W-1:0] b,
                                      output frame_result_t r);
    r = '0;
    if (frame_count >= FRAME_LIMIT) begin
      frame_ovf = 1'b1;
      return 1'b0;
    end
    r = make_result(KIND_BYTE, b, frame_count, 1'b0);
    frame_count++;
    return 1'b1;
  endfunction

  function automatic bit deframe_step(input logic [BYTE_W-1:0] b,
                                      output frame_result_t r);
    bit hit;
    r = '0;
    hit = 1'b0;
    case (rx_mode)
      MODE_DATA: begin
        // start wins over end, end over escape
        if (b == cur_start) begin
          r = make_result(KIND_ABORT, '0, frame_count, frame_ovf);
          hit = 1'b1;
          frame_count = 0;
          frame_ovf = 1'b0;
        end else if (b == cur_end) begin
          r = make_result(KIND_DONE, '0, frame_count, frame_ovf);
          hit = 1'b1;
          rx_mode = MODE_IDLE;
          frame_count = 0;
          frame_ovf = 1'b0;
        end else if (b == cur_escape) begin
          rx_mode = MODE_ESC;
        end else begin
          hit = keep_payload(b, r);
        end
      end
      MODE_ESC: begin
        if (b == cur_start || b == cur_end || b == cur_escape) begin
          rx_mode = MODE_DATA;
          hit = keep_payload(b, r);
        end else begin
          // bad escape drops the frame
          r = make_result(KIND_ABORT, '0, frame_count, frame_ovf);
          hit = 1'b1;
          rx_mode = MODE_IDLE;
          frame_count = 0;
          frame_ovf = 1'b0;
        end
      end
      default: begin
        rx_mode = MODE_IDLE;
        if (b == cur_start) begin
          rx_mode = MODE_DATA;
          frame_count = 0;
          frame_ovf = 1'b0;
        end
      end
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    while (gaps_on && $urandom_range(99) < 22) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    if (rx_mode != MODE_IDLE || b == cur_start) frame_items++;
    bytes_sent++;
    if (deframe_step(b, r)) pending_results.push_back(r);
  endtask

  // drop valid, let every outstanding result arrive, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_CODE: cur_start = v;
      REG_END_CODE:   cur_end = v;
      default:        cur_escape = v;
    endcase
  endtask

  task automatic set_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                           input logic [BYTE_W-1:0] x);
    write_reg(REG_START_CODE, s);
    write_reg(REG_END_CODE, e);
    write_reg(REG_ESCAPE_CODE, x);
  endtask

  function automatic bit is_code(input logic [BYTE_W-1:0] b);
    return b == cur_start || b == cur_end || b == cur_escape;
  endfunction

  // byte that none of the current codes match
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255)); while (is_code(b));
    return b;
  endfunction

  // frame content leaning on the control codes
  function automatic logic [BYTE_W-1:0] content_byte();
    case ($urandom_range(7))
      0:       return cur_start;
      1:       return cur_end;
      2:       return cur_escape;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  // payload byte, stuffed when it collides with a code
  task automatic send_payload(input logic [BYTE_W-1:0] b);
    if (is_code(b)) send_byte(cur_escape);
    send_byte(b);
  endtask

  task automatic send_frame(input int unsigned n);
    send_byte(cur_start);
    repeat (n) send_payload(content_byte());
    send_byte(cur_end);
  endtask

  task automatic send_bad_escape(input int unsigned n);
    send_byte(cur_start);
    repeat (n) send_payload(content_byte());
    send_byte(cur_escape);
    send_byte(plain_byte());
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      out_stall <= 1'b1;
      hold_request--;
    end else begin
      out_stall <= stalls_on && ($urandom_range(99) < 22);
    end
  end

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) stall_edges++;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing predicted: kind %0d pos %0d",
               out_kind, out_position);
        fail_count++;
      end else begin
        head = pending_results.pop_front();
        if (head.kind == KIND_DONE) frames_done++;
        if (head.kind == KIND_ABORT) frames_killed++;
        check_field("kind", POS_W'(head.kind), POS_W'(out_kind));
        check_field("payload_byte", POS_W'(head.data), POS_W'(out_payload_byte));
        check_field("position", head.pos, out_position);
        check_field("overflowed", POS_W'(head.ovf), POS_W'(out_overflowed));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("escaped_frame_receiver: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset codes: idle noise, empty frame, stuffing, restart, bad escape
  task automatic test_default_codes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_end);
    send_byte(cur_escape);
    send_byte(cur_start);
    send_byte(cur_end);
    send_byte(cur_start);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_payload(cur_start);
    send_payload(cur_end);
    send_payload(cur_escape);
    send_byte(8'h5A);
    send_byte(cur_end);
    send_byte(cur_start);
    send_byte(8'h11);
    send_byte(cur_start);
    send_byte(8'h22);
    send_byte(cur_escape);
    send_byte(8'h33);
  endtask

  // extreme and coinciding code settings
  task automatic test_register_extremes();
    set_codes(8'hFF, 8'h00, 8'h80);
    send_frame(6);
    send_bad_escape(2);
    set_codes(8'h00, 8'hFF, 8'h01);
    send_frame(6);
    send_bad_escape(1);
    // all three equal: start always wins
    set_codes(8'h55, 8'h55, 8'h55);
    send_byte(8'h55);
    send_byte(8'h12);
    send_byte(8'h55);
    send_byte(8'h34);
    send_byte(8'hAA);
    // end equal to escape: end wins, no escaping possible
    set_codes(8'h01, 8'hAA, 8'hAA);
    send_byte(8'h01);
    send_byte(8'h77);
    send_byte(8'hAA);
    // start equal to end
    set_codes(8'h7F, 8'h7F, 8'h3C);
    send_byte(8'h7F);
    send_byte(8'h3C);
    send_byte(8'h7F);
    send_byte(8'h3C);
    send_byte(8'h99);
    send_byte(8'h7F);
  endtask

  // frame past the length limit, an escaped byte dropped there, closed by end
  task automatic test_overflow();
    set_codes(START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
    send_byte(cur_start);
    repeat (FRAME_LIMIT + 1) send_byte(plain_byte());
    send_payload(cur_escape);
    send_byte(cur_end);
  endtask

  // consumer holds off while the sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    gaps_on = 1'b0;
    hold_request = 200;
    send_frame(40);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // random codes per phase, mostly well-formed frames with random content
  task automatic test_random_traffic();
    int unsigned phase_start;
    int unsigned pick;
    for (int phase = 0; phase < 5; phase++) begin
      set_codes(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                BYTE_W'($urandom_range(255)));
      gaps_on   = (phase != 2);
      stalls_on = (phase != 2);
      phase_start = frame_items;
      while (frame_items - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8));
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(255)));
        end else if (pick < 90) begin
          send_bad_escape($urandom_range(5));
        end else begin
          // frame cut short by a new start
          send_byte(cur_start);
          repeat ($urandom_range(4)) send_payload(content_byte());
          send_frame($urandom_range(4));
        end
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_codes();
    test_register_extremes();
    test_overflow();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("sent %0d bytes, %0d inside frames; checked %0d results", bytes_sent,
             frame_items, results_seen);
    $display("%0d frames completed, %0d aborted or restarted, %0d input stall edges",
             frames_done, frames_killed, stall_edges);
    if (fail_count == 0) begin
      $display("escaped_frame_receiver: match");
    end else begin
      $display("escaped_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
